// ----- hw/rtl/plcs_pkg.sv -----
// ----------------------------------------------------------------------------
// plcs_pkg
// Shared types, codes and constants of the piecewise-linear CDF sampler.
// ----------------------------------------------------------------------------
package plcs_pkg;

    localparam int FRAC_BITS = 14;              // slope fraction bits

    localparam logic [6:0] POINTS_RESET = 7'd46;

    // register index (paddr[2])
    localparam logic CFG_POINTS_IN_USE = 1'b0;

    typedef logic [1:0] status_t;
    localparam status_t ST_SAMPLE = 2'd0;
    localparam status_t ST_LOADED = 2'd1;
    localparam status_t ST_RANGE  = 2'd2;

    // table read requests
    typedef logic [2:0] rd_sel_t;
    localparam rd_sel_t RD_NONE      = 3'd0;
    localparam rd_sel_t RD_PREV      = 3'd1;   // pos/dens/cum at idx-1
    localparam rd_sel_t RD_TOTAL     = 3'd2;   // cum at n-1
    localparam rd_sel_t RD_SCAN_INIT = 3'd3;   // cum at n-2, j = n-2
    localparam rd_sel_t RD_SCAN_NEXT = 3'd4;   // cum at j-1, j = j-1
    localparam rd_sel_t RD_SEG       = 3'd5;   // pos/dens/slope at j, latch r
    localparam rd_sel_t RD_NEXT_POS  = 3'd6;   // pos at j+1, latch pos[j]

    // shared 32x32 multiplier operand pairs
    typedef logic [3:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE  = 4'd0;
    localparam mul_sel_t MUL_AREA  = 4'd1;
    localparam mul_sel_t MUL_CLO_U = 4'd2;
    localparam mul_sel_t MUL_CHI_U = 4'd3;
    localparam mul_sel_t MUL_A0R0  = 4'd4;
    localparam mul_sel_t MUL_A0R1  = 4'd5;
    localparam mul_sel_t MUL_A1R0  = 4'd6;
    localparam mul_sel_t MUL_A1R1  = 4'd7;
    localparam mul_sel_t MUL_YY    = 4'd8;

    typedef logic [1:0] acc_op_t;
    localparam acc_op_t ACC_HOLD  = 2'd0;
    localparam acc_op_t ACC_LOAD  = 2'd1;
    localparam acc_op_t ACC_ADD32 = 2'd2;
    localparam acc_op_t ACC_ADD64 = 2'd3;

    typedef logic [1:0] div_src_t;
    localparam div_src_t DIV_SLOPE  = 2'd0;
    localparam div_src_t DIV_FLAT   = 2'd1;
    localparam div_src_t DIV_SLOPED = 2'd2;

    typedef logic [1:0] d_op_t;
    localparam d_op_t D_HOLD = 2'd0;
    localparam d_op_t D_ZERO = 2'd1;
    localparam d_op_t D_DIV  = 2'd2;

    typedef struct packed {
        logic      capture;
        logic      pt_we;
        logic      cum_we;
        logic      slope_we;
        rd_sel_t   rd_sel;
        mul_sel_t  mul_sel;
        acc_op_t   acc_op;
        logic      div_start;
        div_src_t  div_src;
        logic      sqrt_start;
        d_op_t     d_op;
        logic      out_load;
        status_t   out_status;
    } plcs_cmd_t;

    typedef struct packed {
        logic kind;
        logic idx_oor;
        logic idx_zero;
        logic dx_zero;
        logic scan_more;
        logic slope_zero;
        logic dens_zero;
        logic den_zero;
        logic div_busy;
        logic sqrt_busy;
    } plcs_sts_t;

endpackage

// ----- hw/rtl/plcs_ram.sv -----
// ----------------------------------------------------------------------------
// plcs_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module plcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/plcs_div.sv -----
// ----------------------------------------------------------------------------
// plcs_div
// 64/64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic        fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[63]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 6'd63;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[63:0] : shifted[63:0];
            quo_next = {quo_reg[62:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/plcs_sqrt.sv -----
// ----------------------------------------------------------------------------
// plcs_sqrt
// 64-bit integer square root (floor), two radicand bits per cycle.
// ----------------------------------------------------------------------------
module plcs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [63:0] trial;

    always_comb begin
        trial     = res_reg + bit_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start) begin
            v_next    = radicand;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

// ----- hw/rtl/plcs_datapath.sv -----
// ----------------------------------------------------------------------------
// plcs_datapath
// Tables, shared multiplier, accumulator, divider, square root, result regs.
// ----------------------------------------------------------------------------
module plcs_datapath import plcs_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_kind,
    input  logic [5:0]  s_point_index,
    input  logic [31:0] s_point_position,
    input  logic [31:0] s_point_density,
    input  logic [31:0] s_uniform_fraction,
    input  logic [6:0]  points_in_use,
    input  plcs_cmd_t   cmd,
    output plcs_sts_t   sts,
    output logic [31:0] m_sample_value,
    output logic [1:0]  m_status
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);

    // captured item
    logic        kind_reg;
    logic [5:0]  idx_reg;
    logic [31:0] x_reg, y_reg, u_reg;

    logic [AW-1:0]  j_reg;
    logic [63:0]    r_reg;
    logic [31:0]    pos_j_reg;
    logic [111:0]   acc_reg;
    logic [63:0]    prod_reg;
    logic [63:0]    d_reg;
    logic [31:0]    value_reg;
    status_t        status_reg;

    logic [31:0] pos_rd, dens_rd;
    logic [47:0] slope_rd;
    logic [63:0] cum_rd;

    logic [NW-1:0] n_eff;
    logic [AW-1:0] idx_a, last_a, scan0_a;
    logic          pos_re, dens_re, slope_re, cum_re;
    logic [AW-1:0] pos_ra, dens_ra, slope_ra, cum_ra;

    // load arithmetic
    logic [31:0] dx, mag;
    logic        ld_neg;
    logic [32:0] ysum;
    logic [63:0] area;
    logic [64:0] cum_sum;
    logic [63:0] cum_wdata;
    logic [47:0] slope_q, slope_wdata;

    // sample arithmetic
    logic [63:0] t;
    logic        s_neg;
    logic [47:0] ma;
    logic [63:0] m_sat, dd;
    logic [64:0] dd_sum;
    logic [33:0] den;
    logic [31:0] w, d_min;
    logic [32:0] res_sum;
    logic [31:0] res_value;
    logic        round_up;
    logic [63:0] d_div;

    logic [31:0] mul_a, mul_b;
    logic [63:0] div_dividend, div_divisor, div_q, div_r;
    logic        div_busy, sqrt_busy;
    logic [31:0] sq_root;

    // effective point count, clamped to [2, MAX_POINTS]
    always_comb begin
        if (points_in_use < 7'd2) begin
            n_eff = NW'(2);
        end else if (32'(points_in_use) > MAX_POINTS) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(points_in_use);
        end
    end

    assign idx_a   = AW'(32'(idx_reg));
    assign last_a  = AW'(32'(n_eff) - 32'd1);
    assign scan0_a = AW'(32'(n_eff) - 32'd2);

    // ---- load: segment i-1 from stored point and the new point
    assign dx      = (x_reg > pos_rd) ? x_reg - pos_rd : 32'd0;
    assign ld_neg  = y_reg < dens_rd;
    assign mag     = ld_neg ? dens_rd - y_reg : y_reg - dens_rd;
    assign ysum    = {1'b0, dens_rd} + {1'b0, y_reg};
    assign area    = prod_reg + (ysum[0] ? {33'd0, dx[31:1]} : 64'd0);
    assign cum_sum = {1'b0, cum_rd} + {1'b0, area};

    always_comb begin
        if (idx_reg == 6'd0) begin
            cum_wdata = '0;
        end else if (dx == 32'd0) begin
            cum_wdata = cum_rd;
        end else if (cum_sum[64]) begin
            cum_wdata = '1;
        end else begin
            cum_wdata = cum_sum[63:0];
        end
    end

    assign slope_q     = div_q[47:0];
    assign slope_wdata = (dx == 32'd0) ? 48'd0 : (ld_neg ? -slope_q : slope_q);

    // ---- sample
    assign t      = acc_reg[95:32];
    assign s_neg  = slope_rd[47];
    assign ma     = s_neg ? -slope_rd : slope_rd;
    assign m_sat  = (|acc_reg[111:77]) ? '1 : acc_reg[76:13];
    assign dd_sum = {1'b0, prod_reg} + {1'b0, m_sat};

    always_comb begin
        if (s_neg) begin
            dd = (m_sat > prod_reg) ? 64'd0 : prod_reg - m_sat;
        end else begin
            dd = dd_sum[64] ? '1 : dd_sum[63:0];
        end
    end

    assign den      = {2'b0, dens_rd} + {2'b0, sq_root};
    assign round_up = {div_r, 1'b0} >= 65'(den);
    assign d_div    = (slope_rd == 48'd0) ? div_q :
                      (div_q[63] ? '1 : {div_q[62:0], round_up});

    assign w         = (pos_rd > pos_j_reg) ? pos_rd - pos_j_reg : 32'd0;
    assign d_min     = (d_reg > {32'd0, w}) ? w : d_reg[31:0];
    assign res_sum   = {1'b0, pos_j_reg} + {1'b0, d_min};
    assign res_value = res_sum[32] ? '1 : res_sum[31:0];

    // ---- shared 32x32 multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            MUL_AREA: begin
                mul_a = ysum[32:1];
                mul_b = dx;
            end
            MUL_CLO_U: begin
                mul_a = cum_rd[31:0];
                mul_b = u_reg;
            end
            MUL_CHI_U: begin
                mul_a = cum_rd[63:32];
                mul_b = u_reg;
            end
            MUL_A0R0: begin
                mul_a = ma[31:0];
                mul_b = r_reg[31:0];
            end
            MUL_A0R1: begin
                mul_a = ma[31:0];
                mul_b = r_reg[63:32];
            end
            MUL_A1R0: begin
                mul_a = {16'd0, ma[47:32]};
                mul_b = r_reg[31:0];
            end
            MUL_A1R1: begin
                mul_a = {16'd0, ma[47:32]};
                mul_b = r_reg[63:32];
            end
            MUL_YY: begin
                mul_a = dens_rd;
                mul_b = dens_rd;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---- table read ports
    always_comb begin
        pos_re   = 1'b0;
        dens_re  = 1'b0;
        slope_re = 1'b0;
        cum_re   = 1'b0;
        pos_ra   = j_reg;
        dens_ra  = j_reg;
        slope_ra = j_reg;
        cum_ra   = j_reg;
        case (cmd.rd_sel)
            RD_PREV: begin
                pos_re  = 1'b1;
                dens_re = 1'b1;
                cum_re  = 1'b1;
                pos_ra  = idx_a - AW'(1);
                dens_ra = idx_a - AW'(1);
                cum_ra  = idx_a - AW'(1);
            end
            RD_TOTAL: begin
                cum_re = 1'b1;
                cum_ra = last_a;
            end
            RD_SCAN_INIT: begin
                cum_re = 1'b1;
                cum_ra = scan0_a;
            end
            RD_SCAN_NEXT: begin
                cum_re = 1'b1;
                cum_ra = j_reg - AW'(1);
            end
            RD_SEG: begin
                pos_re   = 1'b1;
                dens_re  = 1'b1;
                slope_re = 1'b1;
            end
            RD_NEXT_POS: begin
                pos_re = 1'b1;
                pos_ra = j_reg + AW'(1);
            end
            default: begin
            end
        endcase
    end

    // ---- divider operands
    always_comb begin
        case (cmd.div_src)
            DIV_SLOPE: begin
                div_dividend = {18'd0, mag, 14'd0};
                div_divisor  = {32'd0, dx};
            end
            DIV_FLAT: begin
                div_dividend = r_reg;
                div_divisor  = {32'd0, dens_rd};
            end
            default: begin
                div_dividend = r_reg;
                div_divisor  = {30'd0, den};
            end
        endcase
    end

    // ---- registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            idx_reg  <= s_point_index;
            x_reg    <= s_point_position;
            y_reg    <= s_point_density;
            u_reg    <= s_uniform_fraction;
        end
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.acc_op)
            ACC_LOAD:  acc_reg <= {48'd0, prod_reg};
            ACC_ADD32: acc_reg <= acc_reg + ({48'd0, prod_reg} << 32);
            ACC_ADD64: acc_reg <= acc_reg + ({48'd0, prod_reg} << 64);
            default:   acc_reg <= acc_reg;
        endcase
        case (cmd.rd_sel)
            RD_SCAN_INIT: j_reg <= scan0_a;
            RD_SCAN_NEXT: j_reg <= j_reg - AW'(1);
            RD_SEG:       r_reg <= (t >= cum_rd) ? t - cum_rd : 64'd0;
            RD_NEXT_POS:  pos_j_reg <= pos_rd;
            default: begin
            end
        endcase
        case (cmd.d_op)
            D_ZERO:  d_reg <= '0;
            D_DIV:   d_reg <= d_div;
            default: d_reg <= d_reg;
        endcase
        if (cmd.out_load) begin
            value_reg  <= kind_reg ? res_value : 32'd0;
            status_reg <= cmd.out_status;
        end
    end

    plcs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pos_ram (
        .aclk(aclk), .we(cmd.pt_we), .waddr(idx_a), .wdata(x_reg),
        .re(pos_re), .raddr(pos_ra), .rdata(pos_rd)
    );

    plcs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_dens_ram (
        .aclk(aclk), .we(cmd.pt_we), .waddr(idx_a), .wdata(y_reg),
        .re(dens_re), .raddr(dens_ra), .rdata(dens_rd)
    );

    plcs_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_slope_ram (
        .aclk(aclk), .we(cmd.slope_we), .waddr(idx_a - AW'(1)), .wdata(slope_wdata),
        .re(slope_re), .raddr(slope_ra), .rdata(slope_rd)
    );

    plcs_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_cum_ram (
        .aclk(aclk), .we(cmd.cum_we), .waddr(idx_a), .wdata(cum_wdata),
        .re(cum_re), .raddr(cum_ra), .rdata(cum_rd)
    );

    plcs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(div_dividend), .divisor(div_divisor),
        .busy(div_busy), .quotient(div_q), .remainder(div_r)
    );

    plcs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.sqrt_start),
        .radicand(dd), .busy(sqrt_busy), .root(sq_root)
    );

    always_comb begin
        sts.kind       = kind_reg;
        sts.idx_oor    = 32'(idx_reg) >= 32'(n_eff);
        sts.idx_zero   = idx_reg == 6'd0;
        sts.dx_zero    = dx == 32'd0;
        sts.scan_more  = (cum_rd > t) && (j_reg != '0);
        sts.slope_zero = slope_rd == 48'd0;
        sts.dens_zero  = dens_rd == 32'd0;
        sts.den_zero   = den == 34'd0;
        sts.div_busy   = div_busy;
        sts.sqrt_busy  = sqrt_busy;
    end

    assign m_sample_value = value_reg;
    assign m_status       = status_reg;

endmodule

// ----- hw/rtl/plcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// plcs_ctrl
// Sequencer: load and sample flows, handshakes, output valid.
// ----------------------------------------------------------------------------
module plcs_ctrl import plcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  plcs_sts_t sts,
    output plcs_cmd_t cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_LD_CALC  = 5'd2;
    localparam logic [4:0] S_LD_WAIT  = 5'd3;
    localparam logic [4:0] S_T0       = 5'd4;
    localparam logic [4:0] S_T1       = 5'd5;
    localparam logic [4:0] S_T2       = 5'd6;
    localparam logic [4:0] S_SCAN     = 5'd7;
    localparam logic [4:0] S_SEG      = 5'd8;
    localparam logic [4:0] S_BRANCH   = 5'd9;
    localparam logic [4:0] S_M1       = 5'd10;
    localparam logic [4:0] S_M2       = 5'd11;
    localparam logic [4:0] S_M3       = 5'd12;
    localparam logic [4:0] S_M4       = 5'd13;
    localparam logic [4:0] S_M5       = 5'd14;
    localparam logic [4:0] S_SQW      = 5'd15;
    localparam logic [4:0] S_DIVW     = 5'd16;
    localparam logic [4:0] S_DONE     = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    status_t    st_reg, st_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        st_next      = st_reg;
        cmd          = '0;
        cmd.out_status = st_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.kind) begin
                    st_next    = ST_SAMPLE;
                    cmd.rd_sel = RD_TOTAL;
                    state_next = S_T0;
                end else if (sts.idx_oor) begin
                    st_next    = ST_RANGE;
                    state_next = S_DONE;
                end else begin
                    st_next   = ST_LOADED;
                    cmd.pt_we = 1'b1;
                    if (sts.idx_zero) begin
                        cmd.cum_we = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        cmd.rd_sel = RD_PREV;
                        state_next = S_LD_CALC;
                    end
                end
            end
            S_LD_CALC: begin
                if (sts.dx_zero) begin
                    cmd.slope_we = 1'b1;
                    cmd.cum_we   = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SLOPE;
                    cmd.mul_sel   = MUL_AREA;
                    state_next    = S_LD_WAIT;
                end
            end
            S_LD_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.slope_we = 1'b1;
                    cmd.cum_we   = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_T0: begin
                cmd.mul_sel = MUL_CLO_U;
                state_next  = S_T1;
            end
            S_T1: begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_CHI_U;
                state_next  = S_T2;
            end
            S_T2: begin
                cmd.acc_op = ACC_ADD32;
                cmd.rd_sel = RD_SCAN_INIT;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (sts.scan_more) begin
                    cmd.rd_sel = RD_SCAN_NEXT;
                end else begin
                    cmd.rd_sel = RD_SEG;
                    state_next = S_SEG;
                end
            end
            S_SEG: begin
                cmd.rd_sel = RD_NEXT_POS;
                state_next = S_BRANCH;
            end
            S_BRANCH: begin
                if (!sts.slope_zero) begin
                    cmd.mul_sel = MUL_A0R0;
                    state_next  = S_M1;
                end else if (sts.dens_zero) begin
                    cmd.d_op   = D_ZERO;
                    state_next = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_FLAT;
                    state_next    = S_DIVW;
                end
            end
            S_M1: begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_A0R1;
                state_next  = S_M2;
            end
            S_M2: begin
                cmd.acc_op  = ACC_ADD32;
                cmd.mul_sel = MUL_A1R0;
                state_next  = S_M3;
            end
            S_M3: begin
                cmd.acc_op  = ACC_ADD32;
                cmd.mul_sel = MUL_A1R1;
                state_next  = S_M4;
            end
            S_M4: begin
                cmd.acc_op  = ACC_ADD64;
                cmd.mul_sel = MUL_YY;
                state_next  = S_M5;
            end
            S_M5: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQW;
            end
            S_SQW: begin
                if (!sts.sqrt_busy) begin
                    if (sts.den_zero) begin
                        cmd.d_op   = D_ZERO;
                        state_next = S_DONE;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_src   = DIV_SLOPED;
                        state_next    = S_DIVW;
                    end
                end
            end
            S_DIVW: begin
                if (!sts.div_busy) begin
                    cmd.d_op   = D_DIV;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            st_reg      <= ST_SAMPLE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            st_reg      <= st_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule

// ----- hw/rtl/piecewise_linear_inverse_cdf_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_inverse_cdf_sampler_unit
// Inverse-transform sampler over a tabulated piecewise-linear density.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready  | kind, point_index, position, density, u
//  m_      | out | m_valid / m_ready  | sample_value, status
//  apb     | in  | psel/penable/pready| points_in_use at byte address 0
//
//  One item at a time. Loads: point 0 or a bad index goes straight to the
//  result, a flat-width segment is stored without a divide, any other runs
//  the 64-step slope divide. Samples: a scan of the bins, then a divide for
//  a flat segment, or a 32-step root and a 64-step divide for a sloped one.
//  The result sits in an output register; the next beat is taken as soon
//  as the sequencer is back in idle, even while that result waits.
//  Reset: synchronous, active low; table contents are not cleared.
//
module piecewise_linear_inverse_cdf_sampler_unit import plcs_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [5:0]  s_point_index,
    input  logic [31:0] s_point_position,
    input  logic [31:0] s_point_density,
    input  logic [31:0] s_uniform_fraction,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sample_value,
    output logic [1:0]  m_status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    plcs_cmd_t  cmd;
    plcs_sts_t  sts;
    logic [6:0] points_reg;
    logic       cfg_hit;

    // register file: a single word, upper word of the map reads as zero
    assign cfg_hit = paddr[2] == CFG_POINTS_IN_USE;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {25'd0, points_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= POINTS_RESET;
        end else if (psel && penable && pwrite && cfg_hit) begin
            points_reg <= pwdata[6:0];
        end
    end

    plcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    plcs_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_kind             (s_kind),
        .s_point_index      (s_point_index),
        .s_point_position   (s_point_position),
        .s_point_density    (s_point_density),
        .s_uniform_fraction (s_uniform_fraction),
        .points_in_use      (points_reg),
        .cmd                (cmd),
        .sts                (sts),
        .m_sample_value     (m_sample_value),
        .m_status           (m_status)
    );

endmodule
